// ===== hdl/gics_pkg.sv =====
// Shared types and constants for the grouped inverse-CDF sampler.
`timescale 1ns / 1ps
package gics_pkg;
  localparam int MAX_POINTS = 1024;
  localparam int GROUPS = 3;
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int GRP_W = 2;
  localparam int ADDR_W = $clog2(GROUPS * MAX_POINTS);
  localparam int CNT_W = 11;
  localparam int CDF_W = 25;
  localparam int EN_W = 20;
  localparam int DRAW_W = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W = 25;
  localparam int QUEUE_DEPTH = 2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_THR0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_N0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_N1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_N2 = 3'd4;

  typedef struct packed {
    logic command;
    logic [1:0] table_group;
    logic [9:0] point_index;
    logic [24:0] cdf_point;
    logic [19:0] energy_point;
    logic [23:0] group_draw;
    logic [23:0] energy_draw;
  } in_beat_t;

  typedef struct packed {
    logic [19:0] sampled_energy;
    logic [1:0] chosen_group;
    logic flat_interval;
  } out_beat_t;

  // classified job passed from front to back
  typedef struct packed {
    logic is_load;
    logic [GRP_W-1:0] grp;
    logic [IDX_W-1:0] idx;
    logic [IDX_W:0] n;
    logic [CDF_W-1:0] cdf;
    logic [EN_W-1:0] energy;
    logic [DRAW_W-1:0] draw;
  } job_t;
endpackage

// ===== hdl/gics_front.sv =====
// Front end: accepts beats, picks the group, clamps the count, queues jobs.
`timescale 1ns / 1ps
module gics_front (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [gics_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gics_pkg::CFG_W-1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  gics_pkg::in_beat_t in_data,
  output logic job_valid,
  input  logic job_take,
  output gics_pkg::job_t job
);
  logic [24:0] thr0_r, thr1_r;
  logic [10:0] n0_r, n1_r, n2_r;
  gics_pkg::job_t q_r [gics_pkg::QUEUE_DEPTH];
  logic [1:0] cnt_r;
  logic wp_r, rp_r;
  logic acc;
  gics_pkg::job_t jn;
  logic [10:0] nraw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr0_r <= 25'd4529848;
      thr1_r <= 25'd15049114;
      n0_r <= 11'd1024;
      n1_r <= 11'd1024;
      n2_r <= 11'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        gics_pkg::REG_THR0: thr0_r <= cfg_data;
        gics_pkg::REG_THR1: thr1_r <= cfg_data;
        gics_pkg::REG_N0: n0_r <= cfg_data[10:0];
        gics_pkg::REG_N1: n1_r <= cfg_data[10:0];
        gics_pkg::REG_N2: n2_r <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    jn = '0;
    jn.is_load = (in_data.command == gics_pkg::CMD_LOAD);
    jn.idx = in_data.point_index;
    jn.cdf = in_data.cdf_point;
    jn.energy = in_data.energy_point;
    jn.draw = in_data.energy_draw;
    if (jn.is_load) begin
      jn.grp = in_data.table_group;
    end else if ({1'b0, in_data.group_draw} < thr0_r) begin
      jn.grp = 2'd0;
    end else if ({1'b0, in_data.group_draw} < thr1_r) begin
      jn.grp = 2'd1;
    end else begin
      jn.grp = 2'd2;
    end
    case (jn.grp)
      2'd0: nraw = n0_r;
      2'd1: nraw = n1_r;
      default: nraw = n2_r;
    endcase
    if (nraw < 11'd2) jn.n = 11'd2;
    else if (nraw > 11'(gics_pkg::MAX_POINTS)) jn.n = 11'(gics_pkg::MAX_POINTS);
    else jn.n = nraw;
  end

  assign in_stall = (cnt_r == 2'(gics_pkg::QUEUE_DEPTH));
  assign acc = in_valid && !in_stall;
  assign job_valid = (cnt_r != 2'd0);
  assign job = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (acc) q_r[wp_r] <= jn;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      if (acc) wp_r <= ~wp_r;
      if (job_take) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(acc) - 2'(job_take);
    end
  end

`ifndef ASSERT_OFF
  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(gics_pkg::QUEUE_DEPTH)) else $error("queue overflow");
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    job_take |-> job_valid) else $error("take from empty queue");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'(gics_pkg::QUEUE_DEPTH) && !job_take) |=> in_stall)
    else $error("full queue not stalling");
`endif
endmodule

// ===== hdl/gics_back.sv =====
// Back end: table memories, bracket search and interpolation divider.
`timescale 1ns / 1ps
module gics_back (
  input  logic clk,
  input  logic rst_n,
  input  logic job_valid,
  output logic job_take,
  input  gics_pkg::job_t job,
  output logic out_valid,
  input  logic out_stall,
  output gics_pkg::out_beat_t out_data
);
  localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_WT = 3'd2, S_CMP = 3'd3,
    S_LOW = 3'd4, S_HIW = 3'd5, S_MUL = 3'd6, S_DIV = 3'd7;
  localparam int IW = gics_pkg::IDX_W;

  logic [24:0] cdf_mem [gics_pkg::GROUPS * gics_pkg::MAX_POINTS];
  logic [19:0] en_mem [gics_pkg::GROUPS * gics_pkg::MAX_POINTS];
  logic [24:0] cdf_q_r;
  logic [19:0] en_q_r;
  logic [gics_pkg::ADDR_W-1:0] ra;
  logic [2:0] st_r;
  gics_pkg::job_t j_r;
  logic [IW-1:0] lo_r, hi_r, ra_idx;
  logic [IW:0] mid;
  logic phase_r;
  logic [24:0] clo_r;
  logic [19:0] elo_r, ehi_r;
  logic [24:0] d_r, u_r;
  logic [44:0] rem_r;
  logic [19:0] q_r;
  logic [4:0] bit_r;
  logic down_r;
  logic [45:0] trial;
  logic [19:0] diff;
  logic ov_r;
  gics_pkg::out_beat_t ob_r;

  assign mid = ({1'b0, lo_r} + {1'b0, hi_r}) >> 1;
  always_comb begin
    case (st_r)
      S_LOW: ra_idx = phase_r ? hi_r : lo_r;
      default: ra_idx = mid[IW-1:0];
    endcase
    if (st_r == S_HIW || st_r == S_MUL) ra_idx = hi_r;
  end
  assign ra = gics_pkg::ADDR_W'(j_r.grp) * gics_pkg::ADDR_W'(gics_pkg::MAX_POINTS)
    + gics_pkg::ADDR_W'(ra_idx);

  logic wr_en;
  logic [gics_pkg::ADDR_W-1:0] wa;
  assign wr_en = (st_r == S_IDLE) && job_valid && job.is_load &&
    (job.grp < 2'(gics_pkg::GROUPS));
  assign wa = gics_pkg::ADDR_W'(job.grp) * gics_pkg::ADDR_W'(gics_pkg::MAX_POINTS)
    + gics_pkg::ADDR_W'(job.idx);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cdf_mem[wa] <= job.cdf;
      en_mem[wa] <= job.energy;
    end
    cdf_q_r <= cdf_mem[ra];
    en_q_r <= en_mem[ra];
  end

  assign job_take = (st_r == S_IDLE) && job_valid && (job.is_load || !ov_r);
  assign out_valid = ov_r;
  assign out_data = ob_r;
  assign trial = {1'b0, rem_r} - ({21'd0, d_r} << bit_r);
  assign diff = (ehi_r >= elo_r) ? ehi_r - elo_r : elo_r - ehi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      if (ov_r && !out_stall) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: if (job_take && !job.is_load) begin
          j_r <= job;
          lo_r <= '0;
          hi_r <= IW'(job.n - 1'b1);
          st_r <= S_RD;
        end
        S_RD: begin
          if (hi_r - lo_r > IW'(1)) st_r <= S_WT;
          else begin
            phase_r <= 1'b0;
            st_r <= S_LOW;
          end
        end
        S_WT: st_r <= S_CMP;
        S_CMP: begin
          if (cdf_q_r < {1'b0, j_r.draw}) lo_r <= mid[IW-1:0];
          else hi_r <= mid[IW-1:0];
          st_r <= S_RD;
        end
        S_LOW: begin
          // address lo issued; next cycle issue hi
          phase_r <= 1'b1;
          st_r <= S_HIW;
        end
        S_HIW: begin
          clo_r <= cdf_q_r;
          elo_r <= en_q_r;
          st_r <= S_MUL;
          phase_r <= 1'b0;
        end
        S_MUL: begin
          if (!phase_r) begin
            phase_r <= 1'b1;
          end else begin
            ehi_r <= en_q_r;
            down_r <= en_q_r < elo_r;
            if (cdf_q_r <= clo_r) begin
              ob_r <= '{sampled_energy: elo_r, chosen_group: j_r.grp, flat_interval: 1'b1};
              ov_r <= 1'b1;
              st_r <= S_IDLE;
            end else begin
              d_r <= cdf_q_r - clo_r;
              if ({1'b0, j_r.draw} <= clo_r) u_r <= 25'd0;
              else if ({1'b0, j_r.draw} - clo_r > cdf_q_r - clo_r) u_r <= cdf_q_r - clo_r;
              else u_r <= {1'b0, j_r.draw} - clo_r;
              rem_r <= '0;
              bit_r <= 5'd20;
              st_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (bit_r == 5'd20) begin
            rem_r <= 45'(u_r) * 45'(diff);
            q_r <= '0;
            bit_r <= 5'd19;
          end else begin
            if (!trial[45]) begin
              rem_r <= trial[44:0];
              q_r[bit_r] <= 1'b1;
            end
            if (bit_r == 5'd0) begin
              st_r <= S_IDLE;
              ov_r <= 1'b1;
              ob_r.chosen_group <= j_r.grp;
              ob_r.flat_interval <= 1'b0;
              ob_r.sampled_energy <= down_r ?
                elo_r - (q_r | (trial[45] ? 20'd0 : 20'd1)) :
                elo_r + (q_r | (trial[45] ? 20'd0 : 20'd1));
            end else begin
              bit_r <= bit_r - 5'd1;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_bracket: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CMP) |-> (lo_r < hi_r)) else $error("bracket collapsed");
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> (ov_r && $stable(ob_r))) else $error("result lost");
  a_div_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DIV) |-> (d_r != 25'd0)) else $error("zero divisor");
`endif
endmodule

// ===== hdl/grouped_inverse_cdf_sampler_core.sv =====
// Top level of the grouped inverse-CDF energy sampler.
// Input channel in_valid/in_stall/in_data carries load or sample beats.
// A load writes one CDF and energy point and gives no result.
// A sample picks a group with group_draw, brackets energy_draw in that
// group's CDF table by binary search and interpolates the energy.
// Result channel out_valid/out_stall/out_data carries one beat per sample.
// Config: cfg_we writes register cfg_index with cfg_data; write only idle.
// A two-entry job queue splits the front (classify) from the back (execute).
// Per sample: a pass through the job queue, then search steps of S_RD, S_WT
// and S_CMP (10 steps for 1024 points, one table read port), then S_RD,
// S_LOW, S_HIW and S_MUL close the search and fetch the bracket, then the
// restoring divider runs in S_DIV; a flat interval skips the divider.
// Samples are handled one at a time by the back end; loads are written in S_IDLE.
// Reset clears the queue, the sequencer and the registers to defaults;
// table contents stay undefined until loaded.
// A stalled result holds in the output register; the back end waits before
// taking the next sample job, and the front stalls once the queue is full.
`timescale 1ns / 1ps
module grouped_inverse_cdf_sampler_core (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [gics_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gics_pkg::CFG_W-1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  gics_pkg::in_beat_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output gics_pkg::out_beat_t out_data
);
  logic job_valid, job_take;
  gics_pkg::job_t job;

  gics_front u_front (.clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .in_valid,
    .in_stall, .in_data, .job_valid, .job_take, .job);
  gics_back u_back (.clk, .rst_n, .job_valid, .job_take, .job, .out_valid,
    .out_stall, .out_data);
endmodule

// ===== tb/gics_checker.sv =====
// Checker for the grouped inverse-CDF sampler: predicts results and compares them.
`timescale 1ns / 1ps
module gics_checker
  import gics_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic in_valid,
  input  logic in_stall,
  input  in_beat_t in_data,
  input  logic out_valid,
  input  logic out_stall,
  input  out_beat_t out_data,
  output int pending,
  output int errors
);
  logic [CDF_W-1:0] cdf_mem [GROUPS*MAX_POINTS];
  logic [EN_W-1:0] energy_mem [GROUPS*MAX_POINTS];
  logic [CDF_W-1:0] thr0, thr1;
  logic [CNT_W-1:0] points [GROUPS];
  out_beat_t sample_q[$];

  initial begin
    errors = 0;
    pending = 0;
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic bit predict_sample(input in_beat_t b, output out_beat_t r);
    int unsigned grp, n, lo, hi, mid, base, a;
    logic [CDF_W-1:0] c_lo, c_hi;
    logic [EN_W-1:0] e_lo, e_hi;
    longint unsigned d, u, q;
    r = '0;
    if (b.command == CMD_LOAD) begin
      if (int'(b.table_group) < GROUPS) begin
        a = int'(b.table_group) * MAX_POINTS + int'(b.point_index);
        cdf_mem[a] = b.cdf_point;
        energy_mem[a] = b.energy_point;
      end
      return 1'b0;
    end
    if ({1'b0, b.group_draw} < thr0) grp = 0;
    else if ({1'b0, b.group_draw} < thr1) grp = 1;
    else grp = 2;
    base = grp * MAX_POINTS;
    n = int'(points[grp]);
    if (n < 2) n = 2;
    if (n > MAX_POINTS) n = MAX_POINTS;
    lo = 0;
    hi = n - 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (cdf_mem[base+mid] < {1'b0, b.energy_draw}) lo = mid;
      else hi = mid;
    end
    c_lo = cdf_mem[base+lo];
    c_hi = cdf_mem[base+hi];
    e_lo = energy_mem[base+lo];
    e_hi = energy_mem[base+hi];
    r.chosen_group = grp[1:0];
    if (c_hi <= c_lo) begin
      r.sampled_energy = e_lo;
      r.flat_interval = 1'b1;
    end else begin
      d = longint'(c_hi) - longint'(c_lo);
      u = ({1'b0, b.energy_draw} > c_lo) ? longint'(b.energy_draw) - longint'(c_lo) : 0;
      if (u > d) u = d;
      if (e_hi >= e_lo) begin
        q = (u * (longint'(e_hi) - longint'(e_lo))) / d;
        r.sampled_energy = e_lo + q[EN_W-1:0];
      end else begin
        q = (u * (longint'(e_lo) - longint'(e_hi))) / d;
        r.sampled_energy = e_lo - q[EN_W-1:0];
      end
      r.flat_interval = 1'b0;
    end
    return 1'b1;
  endfunction

  // inputs are driven at posedge; values seen at negedge hold through the next edge
  always @(negedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      thr0 = 25'd4529848;
      thr1 = 25'd15049114;
      for (int g = 0; g < GROUPS; g++) points[g] = 11'd1024;
      sample_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_THR0: thr0 = cfg_data;
          REG_THR1: thr1 = cfg_data;
          REG_N0: points[0] = cfg_data[CNT_W-1:0];
          REG_N1: points[1] = cfg_data[CNT_W-1:0];
          REG_N2: points[2] = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (predict_sample(in_data, want)) sample_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (sample_q.size() == 0) begin
          report_mismatch("unexpected result beat", int'(out_data.sampled_energy), 0);
        end else begin
          want = sample_q.pop_front();
          if (out_data.sampled_energy !== want.sampled_energy)
            report_mismatch("sampled_energy", int'(out_data.sampled_energy),
                            int'(want.sampled_energy));
          if (out_data.chosen_group !== want.chosen_group)
            report_mismatch("chosen_group", int'(out_data.chosen_group),
                            int'(want.chosen_group));
          if (out_data.flat_interval !== want.flat_interval)
            report_mismatch("flat_interval", int'(out_data.flat_interval),
                            int'(want.flat_interval));
        end
      end
    end
    pending = sample_q.size();
  end
endmodule

// ===== tb/tb_grouped_inverse_cdf_sampler_core.sv =====
// Testbench top for the grouped inverse-CDF sampler: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb_grouped_inverse_cdf_sampler_core;
  import gics_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 150;

  logic clk, rst_n, cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic in_valid, in_stall, out_valid, out_stall;
  in_beat_t in_data;
  out_beat_t out_data;
  int pending, errors, out_beats, idle_cycles;
  bit quiet;
  int unsigned tb_cdf [GROUPS][MAX_POINTS];
  int unsigned tb_n [GROUPS];

  grouped_inverse_cdf_sampler_core dut (.*);

  gics_checker chk (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .pending, .errors
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  // beat counter and watchdog
  initial begin
    out_beats = 0;
    idle_cycles = 0;
    forever begin
      @(negedge clk);
      if (out_valid && !out_stall) out_beats++;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    quiet = 0;
    forever begin
      repeat (300) @(posedge clk);
      quiet = ($urandom_range(0, 3) == 0);
    end
  end

  // receiver: random stalls, one long hold-off once results are flowing
  initial begin
    int left;
    bit held;
    left = 0;
    held = 0;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!held && out_beats >= 20) begin
        held = 1;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        out_stall <= 1'b0;
      end else if (left > 0) begin
        left--;
        out_stall <= 1'b1;
      end else begin
        left = gap_len();
        out_stall <= (left > 0);
        if (left > 0) left--;
      end
    end
  end

  task automatic send_beat(in_beat_t b);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
      @(posedge clk);
    end
    @(posedge clk);
  endtask

  task automatic send_load(int g, int i, int unsigned c, int unsigned e);
    in_beat_t b;
    b.command = CMD_LOAD;
    b.table_group = 2'(g);
    b.point_index = 10'(i);
    b.cdf_point = 25'(c);
    b.energy_point = 20'(e);
    b.group_draw = 24'($urandom);
    b.energy_draw = 24'($urandom);
    if (g < GROUPS) tb_cdf[g][i] = c;
    send_beat(b);
  endtask

  task automatic send_sample(int unsigned gd, int unsigned ed);
    in_beat_t b;
    b.command = CMD_SAMPLE;
    b.table_group = 2'($urandom);
    b.point_index = 10'($urandom);
    b.cdf_point = 25'($urandom);
    b.energy_point = 20'($urandom);
    b.group_draw = 24'(gd);
    b.energy_draw = 24'(ed);
    send_beat(b);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(int unsigned t0, int unsigned t1, int unsigned n0,
                           int unsigned n1, int unsigned n2);
    int unsigned raw [GROUPS];
    raw = '{n0, n1, n2};
    write_reg(REG_THR0, t0);
    write_reg(REG_THR1, t1);
    write_reg(REG_N0, n0);
    write_reg(REG_N1, n1);
    write_reg(REG_N2, n2);
    for (int g = 0; g < GROUPS; g++) begin
      tb_n[g] = raw[g] & 11'h7ff;
      if (tb_n[g] < 2) tb_n[g] = 2;
      if (tb_n[g] > MAX_POINTS) tb_n[g] = MAX_POINTS;
    end
  endtask

  // monotonic CDF with occasional flat steps, energies rising or falling
  task automatic fill_group(int g);
    int unsigned c, e, n, step, de;
    bit down;
    n = tb_n[g];
    step = 16777216 / n;
    de = 1048575 / n;
    down = $urandom_range(0, 1);
    c = $urandom_range(0, 3000);
    e = down ? $urandom_range(600000, 1048575) : $urandom_range(0, 400000);
    for (int i = 0; i < n; i++) begin
      if (i == n - 1 && $urandom_range(0, 1)) c = 16777216;
      send_load(g, i, c, e);
      if ($urandom_range(0, 7) != 0) c += $urandom_range(1, step);
      if (c > 16777216) c = 16777216;
      if (down) e -= (e < de) ? e : $urandom_range(0, de);
      else e += $urandom_range(0, de);
      if (e > 1048575) e = 1048575;
    end
  endtask

  // full table loaded only where the search runs for draws at either end
  task automatic fill_ends(int g);
    int k;
    for (int j = 0; j < 10; j++) begin
      k = (1 << j) - 1;
      send_load(g, k, k * 8192, $urandom & 20'hfffff);
      k = MAX_POINTS - 1 - (1 << j);
      send_load(g, k, k * 8192, $urandom & 20'hfffff);
    end
    send_load(g, MAX_POINTS - 1, (MAX_POINTS - 1) * 8192, $urandom & 20'hfffff);
  endtask

  task automatic random_beat();
    int r, g;
    int unsigned ed;
    r = $urandom_range(0, 99);
    if (r < 72) begin
      g = $urandom_range(0, GROUPS - 1);
      if ($urandom_range(0, 1)) ed = $urandom & 24'hffffff;
      else begin
        ed = tb_cdf[g][$urandom_range(0, tb_n[g] - 1)] + $urandom_range(0, 4) - 2;
        if (ed > 24'hffffff) ed = ($urandom_range(0, 1)) ? 24'hffffff : 0;
      end
      send_sample($urandom & 24'hffffff, ed);
    end else if (r < 80) begin
      send_load(3, $urandom_range(0, MAX_POINTS - 1), $urandom_range(0, 16777216),
                $urandom & 20'hfffff);
    end else begin
      g = $urandom_range(0, GROUPS - 1);
      send_load(g, $urandom_range(0, MAX_POINTS - 1), $urandom_range(0, 16777216),
                $urandom & 20'hfffff);
    end
  endtask

  initial begin
    int unsigned t0, t1;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: hand-built tables
    configure(4529848, 15049114, 3, 4, 5);
    send_load(0, 0, 100, 0);
    send_load(0, 1, 1000, 1048575);
    send_load(0, 2, 16777216, 500);
    send_load(1, 0, 0, 900000);
    send_load(1, 1, 5000, 800000);
    send_load(1, 2, 5000, 100);
    send_load(1, 3, 9000, 0);
    fill_group(2);
    send_load(3, 7, 16777216, 1048575);
    send_sample(0, 0);
    send_sample(0, 50);
    send_sample(0, 100);
    send_sample(0, 550);
    send_sample(0, 1000);
    send_sample(4529847, 24'hffffff);
    send_sample(4529848, 6000);
    send_sample(4529848, 5000);
    send_sample(4529849, 2500);
    send_sample(15049113, 24'hffffff);
    send_sample(15049114, tb_cdf[2][2]);
    send_sample(24'hffffff, 0);
    send_sample(24'hffffff, 24'hffffff);
    settle();

    // clamped counts, every draw to the full table of group 2 at either end
    configure(0, 0, 0, 1, 2047);
    fill_group(0);
    fill_group(1);
    fill_ends(2);
    for (int s = 0; s < 20; s++) begin
      if (s % 2 == 0) send_sample($urandom & 24'hffffff, $urandom_range(0, 8192));
      else send_sample($urandom & 24'hffffff, $urandom_range(1022 * 8192 + 1, 24'hffffff));
    end
    settle();

    configure(16777216, 16777216, 2, 2, 2);
    for (int g = 0; g < GROUPS; g++) fill_group(g);
    repeat (30) random_beat();
    settle();

    for (int p = 0; p < 4; p++) begin
      t0 = $urandom_range(0, 16777216);
      t1 = $urandom_range(t0, 16777216);
      if (p == 3) configure(33554431, 0, 1, $urandom_range(2, 24), 3);
      else configure(t0, t1, $urandom_range(2, 24), $urandom_range(2, 24),
                     $urandom_range(2, 24));
      for (int g = 0; g < GROUPS; g++) fill_group(g);
      repeat (40) random_beat();
      settle();
    end

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ===== grouped_inverse_cdf_sampler_core.f =====
hdl/gics_pkg.sv
hdl/gics_front.sv
hdl/gics_back.sv
hdl/grouped_inverse_cdf_sampler_core.sv
tb/gics_checker.sv
tb/tb_grouped_inverse_cdf_sampler_core.sv
